>>> rtl/lfu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LFU cache table.
// No dependencies; imported by every module of the block but the entry RAM.
package lfu_pkg;

   localparam int KeyFieldW = 16;
   localparam int ValueW    = 32;
   localparam int CountW    = 16;
   localparam int StampW    = 48;
   localparam int CapW      = 5;

   localparam logic [CapW-1:0]   CapResetVal = 5'd16;
   localparam logic [CountW-1:0] CountMax    = 16'hFFFF;
   localparam logic [CountW-1:0] CountFirst  = 16'd1;

   localparam logic OpGet = 1'b0;
   localparam logic OpPut = 1'b1;

   typedef struct packed {
      logic                     op;
      logic [KeyFieldW-1:0]     key;
      logic signed [ValueW-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [ValueW-1:0] read_value;
   } rsp_type;

   // Status from the scan unit to the sequencer
   typedef struct packed {
      logic found;
      logic free_found;
   } scan_flags_type;

endpackage

>>> rtl/lfu_entry_ram.sv
`timescale 1ns / 1ps
// Entry storage: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
module lfu_entry_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 112,
   parameter int IDX_W = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/lfu_scan_unit.sv
`timescale 1ns / 1ps
// Shared compare unit: examines one entry per cycle for key match,
// first free slot and least-used victim. Depends on lfu_pkg.
module lfu_scan_unit
   import lfu_pkg::*;
#(
   parameter int KEY_W = 16,
   parameter int IDX_W = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic                chk_vld,
   input  logic [IDX_W-1:0]    chk_idx,
   input  logic                chk_used,
   input  logic [KEY_W-1:0]    chk_key,
   input  logic [ValueW-1:0]   chk_value,
   input  logic [CountW-1:0]   chk_count,
   input  logic [StampW-1:0]   chk_stamp,
   input  logic [KEY_W-1:0]    ref_key,
   output scan_flags_type      flags,
   output logic [IDX_W-1:0]    hit_idx_ff,
   output logic [IDX_W-1:0]    free_idx_ff,
   output logic [IDX_W-1:0]    victim_idx_ff,
   output logic [ValueW-1:0]   hit_value_ff,
   output logic [CountW-1:0]   hit_count_ff
);

   logic                     found_ff, found_in;
   logic                     free_found_ff, free_found_in;
   logic                     best_vld_ff, best_vld_in;
   logic [CountW+StampW-1:0] best_ff;
   logic [CountW+StampW-1:0] cand;
   logic                     is_hit, is_free, is_better;

   assign cand      = {chk_count, chk_stamp};
   assign is_hit    = chk_vld && chk_used && (chk_key == ref_key) && !found_ff;
   assign is_free   = chk_vld && !chk_used && !free_found_ff;
   assign is_better = chk_vld && chk_used && (!best_vld_ff || (cand < best_ff));

   always_comb begin
      found_in      = found_ff || is_hit;
      free_found_in = free_found_ff || is_free;
      best_vld_in   = best_vld_ff || is_better;
      if (clear) begin
         found_in      = 1'b0;
         free_found_in = 1'b0;
         best_vld_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         best_vld_ff   <= 1'b0;
      end else begin
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         best_vld_ff   <= best_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (is_hit) begin
         hit_idx_ff   <= chk_idx;
         hit_value_ff <= chk_value;
         hit_count_ff <= chk_count;
      end
      if (is_free) begin
         free_idx_ff <= chk_idx;
      end
      if (is_better) begin
         best_ff       <= cand;
         victim_idx_ff <= chk_idx;
      end
   end

   assign flags.found      = found_ff;
   assign flags.free_found = free_found_ff;

endmodule

>>> rtl/lfu_cache_table.sv
`timescale 1ns / 1ps
// Top level of the LFU cache table: sequencer, valid bits, config register.
// Depends on lfu_pkg, lfu_entry_ram and lfu_scan_unit.
//
//   channel   ports                               handshake
//   -------   ---------------------------------   ------------------------------
//   request   start, busy, req_payload            taken when start && !busy
//   response  rsp_strobe, rsp_payload             one cycle, no back-pressure
//   config    csr_valid, csr_ready, csr_data      taken when csr_valid && csr_ready
//
// Each transaction keeps busy high through a scan of n entries and the
// write-back, n being the effective capacity (min of the capacity register
// and CAPACITY): the entry memory has one read port, so the scan reads one
// entry per cycle, then the decide state writes the chosen entry back.
// The response strobes in the cycle busy drops, which may also take a request.
// Reset is synchronous: the capacity register returns to 16, all entries go
// invalid and the touch counter clears. No clearing pass is needed.
// The response side cannot stall, so nothing is held back for it.
module lfu_cache_table
   import lfu_pkg::*;
#(
   parameter int CAPACITY = 16,
   parameter int KEY_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_type         req_payload,
   output logic            rsp_strobe,
   output rsp_type         rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [CapW-1:0] csr_data
);

   localparam int KeyW = (KEY_BITS < KeyFieldW) ? KEY_BITS : KeyFieldW;
   localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CntW = $clog2(CAPACITY + 1);
   localparam int EntW = KeyW + ValueW + CountW + StampW;

   localparam logic [1:0] StIdle   = 2'd0;
   localparam logic [1:0] StScan   = 2'd1;
   localparam logic [1:0] StDecide = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CapW-1:0]     capacity_ff;
   logic [CAPACITY-1:0] valid_ff;
   logic [StampW-1:0]   touch_ff;
   req_type             req_ff;
   logic [CntW-1:0]     n_ff, n_in;
   logic [CntW-1:0]     issue_ff;
   logic                chk_vld_ff;
   logic [IdxW-1:0]     chk_idx_ff;
   logic                rsp_strobe_ff;
   rsp_type             rsp_ff, rsp_in;

   logic                accept, csr_write, scan_done, issue_more;
   logic                wr_en, insert;
   logic [IdxW-1:0]     wr_idx;
   logic [EntW-1:0]     wr_data, rd_data;
   logic [KeyW-1:0]     req_key;
   logic [KeyW-1:0]     rd_key;
   logic [ValueW-1:0]   rd_value, wr_value;
   logic [CountW-1:0]   rd_count, wr_count;
   logic [StampW-1:0]   rd_stamp;

   scan_flags_type      flags;
   logic [IdxW-1:0]     hit_idx, free_idx, victim_idx;
   logic [ValueW-1:0]   hit_value;
   logic [CountW-1:0]   hit_count;

   assign busy       = (state_ff != StIdle);
   assign csr_ready  = (state_ff == StIdle);
   assign accept     = start && !busy;
   assign csr_write  = csr_valid && csr_ready;
   assign issue_more = (state_ff == StScan) && (issue_ff < n_ff);
   assign scan_done  = (state_ff == StScan) && (issue_ff == n_ff);
   assign req_key    = req_ff.key[KeyW-1:0];

   // Saturate the register at the built-in depth
   assign n_in = ({27'd0, capacity_ff} > CAPACITY) ? CntW'(CAPACITY) : CntW'(capacity_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               state_in = StScan;
            end
         end
         StScan: begin
            if (scan_done) begin
               state_in = StDecide;
            end
         end
         StDecide: begin
            state_in = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   // Latch the request and the effective capacity for this transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
         n_ff   <= n_in;
      end
   end

   // Read address counter; the read data lands in the cycle after the read
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff   <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         if (accept) begin
            issue_ff <= '0;
         end else if (issue_more) begin
            issue_ff <= issue_ff + 1'b1;
         end
         chk_vld_ff <= issue_more;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_more) begin
         chk_idx_ff <= issue_ff[IdxW-1:0];
      end
   end

   assign {rd_key, rd_value, rd_count, rd_stamp} = rd_data;

   lfu_entry_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (EntW),
      .IDX_W (IdxW)
   ) u_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_idx),
      .wr_data    (wr_data),
      .rd_en      (issue_more),
      .rd_addr    (issue_ff[IdxW-1:0]),
      .rd_data_ff (rd_data)
   );

   lfu_scan_unit #(
      .KEY_W (KeyW),
      .IDX_W (IdxW)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .clear         (accept),
      .chk_vld       (chk_vld_ff),
      .chk_idx       (chk_idx_ff),
      .chk_used      (valid_ff[chk_idx_ff]),
      .chk_key       (rd_key),
      .chk_value     (rd_value),
      .chk_count     (rd_count),
      .chk_stamp     (rd_stamp),
      .ref_key       (req_key),
      .flags         (flags),
      .hit_idx_ff    (hit_idx),
      .free_idx_ff   (free_idx),
      .victim_idx_ff (victim_idx),
      .hit_value_ff  (hit_value),
      .hit_count_ff  (hit_count)
   );

   // Write-back: bump a hit, or insert a put miss into a free slot or the victim
   always_comb begin
      insert   = (req_ff.op == OpPut) && !flags.found && (n_ff != '0);
      wr_en    = (state_ff == StDecide) && (flags.found || insert);
      wr_idx   = flags.found ? hit_idx : (flags.free_found ? free_idx : victim_idx);
      wr_value = hit_value;
      wr_count = CountFirst;
      if (req_ff.op == OpPut) begin
         wr_value = req_ff.value;
      end
      if (flags.found) begin
         wr_count = (hit_count == CountMax) ? hit_count : hit_count + 1'b1;
      end
      wr_data = {req_key, wr_value, wr_count, touch_ff};

      rsp_in.hit        = flags.found;
      rsp_in.read_value = '0;
      if (flags.found && (req_ff.op == OpGet)) begin
         rsp_in.read_value = hit_value;
      end
   end

   // Config write clears the store and the touch counter
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CapResetVal;
         valid_ff    <= '0;
         touch_ff    <= '0;
      end else if (csr_write) begin
         capacity_ff <= csr_data;
         valid_ff    <= '0;
         touch_ff    <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
         touch_ff         <= touch_ff + 1'b1;
      end
   end

   // Response register: strobe for one cycle after write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (state_ff == StDecide);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == StDecide) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/lfu_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the LFU cache table, bound onto the top level.
// Depends on lfu_pkg and lfu_cache_table.
module lfu_checker
   import lfu_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            start,
   input logic            busy,
   input logic            rsp_strobe,
   input rsp_type         rsp_payload
);

   // An accepted transaction holds the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // One response per transaction, never on back-to-back cycles
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held two cycles");

   // The response arrives as the block goes idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("response outside end of transaction");

   // A miss never returns data
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_payload.hit) |-> (rsp_payload.read_value == '0))
      else $error("miss returned nonzero data");

   // Out of reset the block is idle and quiet
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("activity right after reset");

endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (.*);

>>> tb/lfu_cache_table_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for lfu_cache_table: LFU replacement with oldest-touch tie-break.
// Depends on lfu_pkg and the lfu_cache_table RTL; needs no other file.
module lfu_cache_table_test;
   import lfu_pkg::*;

   localparam int Slots    = 16;
   localparam int KeyBits  = 16;
   localparam int IdleLimit = 2000;
   localparam logic [KeyFieldW-1:0] KeyMask =
      (KeyBits >= KeyFieldW) ? '1 : KeyFieldW'((1 << KeyBits) - 1);

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   req_type         req_payload = '0;
   logic            rsp_strobe;
   rsp_type         rsp_payload;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [CapW-1:0] csr_data = CapResetVal;

   lfu_cache_table #(
      .CAPACITY (Slots),
      .KEY_BITS (KeyBits)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #6 clock = ~clock;

   // Mirror of the table contents, updated at the edge each transaction is taken.
   logic [CapW-1:0]        cap_reg;
   logic                   tab_valid [Slots];
   logic [KeyFieldW-1:0]   tab_key   [Slots];
   logic signed [ValueW-1:0] tab_value [Slots];
   logic [CountW-1:0]      tab_count [Slots];
   logic [StampW-1:0]      tab_stamp [Slots];
   logic [StampW-1:0]      touch_ctr;

   req_type     pending_reqs [$];   // requests waiting for the driver
   rsp_type     expected_rsps [$];  // predicted responses, oldest first
   int unsigned reqs_queued  = 0;
   int unsigned rsps_seen    = 0;
   bit          failed       = 1'b0;
   logic        req_taken    = 1'b0;
   int unsigned burst_left   = 0;
   int unsigned gap_left     = 0;
   int unsigned idle_cycles  = 0;

   function automatic void clear_table();
      for (int i = 0; i < Slots; i++) begin
         tab_valid[i] = 1'b0;
      end
      touch_ctr = '0;
   endfunction

   function automatic void touch_slot(input int i);
      tab_stamp[i] = touch_ctr;
      touch_ctr    = touch_ctr + 1'b1;
   endfunction

   function automatic int live_slots(input logic [CapW-1:0] cap);
      return (int'(cap) > Slots) ? Slots : int'(cap);
   endfunction

   // Predict one access and update the mirror the way the table does.
   function automatic rsp_type predict_access(input req_type item);
      rsp_type              res;
      int                   n;
      int                   hit_at;
      int                   slot;
      logic [KeyFieldW-1:0] k;
      res    = '0;
      n      = live_slots(cap_reg);
      k      = item.key & KeyMask;
      hit_at = -1;
      for (int i = 0; i < n; i++) begin
         if (hit_at < 0 && tab_valid[i] && tab_key[i] == k) begin
            hit_at = i;
         end
      end
      if (hit_at >= 0) begin
         res.hit = 1'b1;
         if (item.op == OpGet) begin
            res.read_value = tab_value[hit_at];
         end else begin
            tab_value[hit_at] = item.value;
         end
         // Saturate the count but refresh the stamp regardless.
         if (tab_count[hit_at] != CountMax) begin
            tab_count[hit_at] = tab_count[hit_at] + 1'b1;
         end
         touch_slot(hit_at);
         return res;
      end
      if (item.op == OpGet || n == 0) begin
         return res;
      end
      // Take the first free slot, else the lowest count, oldest stamp on a tie.
      slot = -1;
      for (int i = 0; i < n; i++) begin
         if (slot < 0 && !tab_valid[i]) begin
            slot = i;
         end
      end
      if (slot < 0) begin
         slot = 0;
         for (int i = 1; i < n; i++) begin
            if (tab_count[i] < tab_count[slot] ||
                (tab_count[i] == tab_count[slot] && tab_stamp[i] < tab_stamp[slot])) begin
               slot = i;
            end
         end
      end
      tab_valid[slot] = 1'b1;
      tab_key[slot]   = k;
      tab_value[slot] = item.value;
      tab_count[slot] = CountFirst;
      touch_slot(slot);
      return res;
   endfunction

   // Monitor: sample at the rising edge, predict on every request taken,
   // check every response strobe against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cap_reg = CapResetVal;
         clear_table();
         req_taken <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            cap_reg = csr_data;
            clear_table();
         end
         if (start && !busy) begin
            expected_rsps.push_back(predict_access(req_payload));
         end
         req_taken <= start && !busy;
         if (rsp_strobe) begin
            rsps_seen++;
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding");
               failed = 1'b1;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_payload.hit);
                  failed = 1'b1;
               end
               if (rsp_payload.read_value !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d",
                         want.read_value, rsp_payload.read_value);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   // Driver: change inputs at the falling edge. Hold a request until taken,
   // then either idle out a gap or advance to the next pending request.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !req_taken) begin
         // hold: the block has not taken this transaction yet
      end else if (gap_left != 0) begin
         start    <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_reqs.size() != 0) begin
         start       <= 1'b1;
         req_payload <= pending_reqs.pop_front();
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            // Leave about a third of the bursts back to back with the next one.
            gap_left   <= ($urandom_range(0, 2) != 0) ? $urandom_range(1, 24) : 0;
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         start <= 1'b0;
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles == IdleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic queue_req(input logic op, input logic [KeyFieldW-1:0] key,
                            input logic signed [ValueW-1:0] value);
      req_type item;
      item.op    = op;
      item.key   = key;
      item.value = value;
      pending_reqs.push_back(item);
      reqs_queued++;
   endtask

   // Wait until every queued request has produced its response.
   task automatic drain();
      @(negedge clock);
      while (rsps_seen != reqs_queued) begin
         @(negedge clock);
      end
   endtask

   // Write the capacity register; only called while the table is idle.
   task automatic write_capacity(input logic [CapW-1:0] cap);
      @(negedge clock);
      csr_data  <= cap;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random traffic on a small key pool so hits, evictions and count ties
   // are common; lower pool indexes are favored to spread the counts.
   task automatic random_phase(input logic [CapW-1:0] cap, input int n_items);
      int                   pool;
      int                   idx;
      logic [KeyFieldW-1:0] base;
      logic [KeyFieldW-1:0] key;
      write_capacity(cap);
      pool = live_slots(cap) + 1 + $urandom_range(0, 4);
      base = KeyFieldW'($urandom);
      for (int i = 0; i < n_items; i++) begin
         idx = $urandom_range(0, $urandom_range(0, pool - 1));
         key = ($urandom_range(0, 15) == 0) ? KeyFieldW'($urandom) : base ^ KeyFieldW'(idx);
         queue_req($urandom_range(0, 1) ? OpPut : OpGet, key, $urandom);
      end
      drain();
   endtask

   initial begin
      logic [CapW-1:0] caps [11];
      caps = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd3, 5'd17, 5'd8, 5'd0, 5'd0, 5'd2, 5'd16};
      caps[7] = CapW'($urandom_range(1, 16));
      caps[8] = CapW'($urandom);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset capacity: miss on empty table, value extremes, key extremes, put on a hit.
      queue_req(OpGet, 16'h0000, 0);
      queue_req(OpPut, 16'h0000, 32'sh7FFF_FFFF);
      queue_req(OpGet, 16'h0000, 0);
      queue_req(OpPut, 16'h0000, 32'sh8000_0000);
      queue_req(OpGet, 16'h0000, 0);
      queue_req(OpPut, 16'hFFFF, -1);
      queue_req(OpGet, 16'hFFFF, 0);
      queue_req(OpGet, 16'h1234, 0);
      drain();

      // Two slots: capacity write clears, tie on count goes to the older touch,
      // a lower count is evicted before a higher one.
      write_capacity(5'd2);
      queue_req(OpGet, 16'h0000, 0);
      queue_req(OpPut, 16'h0001, 10);
      queue_req(OpPut, 16'h0002, 20);
      queue_req(OpPut, 16'h0003, 30);
      queue_req(OpGet, 16'h0001, 0);
      queue_req(OpGet, 16'h0002, 0);
      queue_req(OpPut, 16'h0004, 40);
      queue_req(OpGet, 16'h0003, 0);
      queue_req(OpGet, 16'h0004, 0);
      queue_req(OpPut, 16'h0005, 50);
      queue_req(OpGet, 16'h0002, 0);
      queue_req(OpGet, 16'h0004, 0);
      drain();

      // Zero capacity: puts are dropped and gets always miss.
      write_capacity(5'd0);
      queue_req(OpPut, 16'h0007, 70);
      queue_req(OpGet, 16'h0007, 0);
      drain();

      foreach (caps[i]) begin
         random_phase(caps[i], 50);
      end

      repeat (4 * Slots) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d predicted responses never arrived", expected_rsps.size());
         failed = 1'b1;
      end
      if (!failed) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
